// ===== design/gate_netlist_bit_parallel_evaluator_defines.svh =====
// Assertion macros shared by the evaluator RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef GATE_NETLIST_BIT_PARALLEL_EVALUATOR_DEFINES_SVH
`define GATE_NETLIST_BIT_PARALLEL_EVALUATOR_DEFINES_SVH
`ifndef ASSERT_OFF
// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/gnbpe_pkg.sv =====
// Package for the gate netlist evaluator: defaults, codes, gate function.
// No dependencies.
package gnbpe_pkg;

  localparam int unsigned NODE_COUNT_DEF   = 256;
  localparam int unsigned VECTOR_WIDTH_DEF = 64;
  localparam int unsigned VEC_PORT_W       = 64;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_GATE = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    GATE_AND    = 3'd0,
    GATE_ANDNOTA = 3'd1,
    GATE_ANDNOT = 3'd2,
    GATE_NOR    = 3'd3,
    GATE_NAND   = 3'd4,
    GATE_ORNOT  = 3'd5,
    GATE_ORNOTA = 3'd6,
    GATE_OR     = 3'd7
  } gate_e;

  // Bitwise gate over full-width vectors; caller trims to its width.
  function automatic logic [VEC_PORT_W-1:0] gate_eval(input gate_e code,
                                                      input logic [VEC_PORT_W-1:0] a,
                                                      input logic [VEC_PORT_W-1:0] b);
    logic [VEC_PORT_W-1:0] r;
    case (code)
      GATE_AND:     r = a & b;
      GATE_ANDNOTA: r = ~a & b;
      GATE_ANDNOT:  r = a & ~b;
      GATE_NOR:     r = ~(a | b);
      GATE_NAND:    r = ~(a & b);
      GATE_ORNOT:   r = a | ~b;
      GATE_ORNOTA:  r = ~a | b;
      GATE_OR:      r = a | b;
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/gnbpe_in_if.sv =====
// Input channel of the evaluator: valid/ready plus one node item.
// No dependencies.
interface gnbpe_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [2:0]  gate_type;
  logic [7:0]  source_a;
  logic [7:0]  source_b;
  logic [63:0] input_vector;
  logic        last_node;

  modport source (output valid, action, gate_type, source_a, source_b, input_vector,
                  last_node, input ready);
  modport sink   (input valid, action, gate_type, source_a, source_b, input_vector,
                  last_node, output ready);
endinterface

// ===== design/gnbpe_out_if.sv =====
// Output channel of the evaluator: valid/ready plus one node result.
// No dependencies.
interface gnbpe_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  node_slot;
  logic [63:0] node_value;
  logic        error;

  modport source (output valid, node_slot, node_value, error, input ready);
  modport sink   (input valid, node_slot, node_value, error, output ready);
endinterface

// ===== design/gnbpe_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old contents.
module gnbpe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/gate_netlist_bit_parallel_evaluator.sv =====
// Gate netlist evaluator, bit-parallel over VECTOR_WIDTH test patterns.
// Stages: item plus operand reads into stage 1, result into the output register.
// Throughput: one item per cycle unless output stalls, dependent gates included;
//   a one-entry write-forward register covers the signal store read/write overlap.
// Reset: clears slot counter and pipeline valids; store contents are not cleared
//   and are only ever used after being written.
`include "gate_netlist_bit_parallel_evaluator_defines.svh"

module gate_netlist_bit_parallel_evaluator #(
  parameter int unsigned NODE_COUNT   = gnbpe_pkg::NODE_COUNT_DEF,
  parameter int unsigned VECTOR_WIDTH = gnbpe_pkg::VECTOR_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gnbpe_in_if.sink    in_i,
  gnbpe_out_if.source out_o
);
  import gnbpe_pkg::*;

  localparam int unsigned ADDR_W = $clog2(NODE_COUNT);
  // Slot counter must be able to hold NODE_COUNT itself (store full).
  localparam int unsigned CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int unsigned CMP_W  = (CNT_W > 8) ? CNT_W : 8;

  // ---------------------------------------------------------------------------
  // Stage 0: on transfer, launch both operand reads. The item itself is
  // latched into stage 1 together with the read data arriving next cycle.
  // ---------------------------------------------------------------------------
  logic              in_xfer;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_adv;
  action_e           s1_action_q;
  gate_e             s1_gate_q;
  logic [7:0]        s1_src_a_q, s1_src_b_q;
  logic [VECTOR_WIDTH-1:0] s1_vec_q;
  logic              s1_last_q;

  // Stage 1 advances into the output register when that register is free
  // or is being drained this cycle.
  assign s1_adv   = s1_valid_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer  = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_action_q <= action_e'(in_i.action);
      s1_gate_q   <= gate_e'(in_i.gate_type);
      s1_src_a_q  <= in_i.source_a;
      s1_src_b_q  <= in_i.source_b;
      s1_vec_q    <= VECTOR_WIDTH'(in_i.input_vector);
      s1_last_q   <= in_i.last_node;
    end
  end

  // ---------------------------------------------------------------------------
  // Signal store: two copies share the write so each gate gets both operands
  // in the same cycle. Out-of-range sources are truncated here; they are rejected
  // by the slot check anyway.
  // ---------------------------------------------------------------------------
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [VECTOR_WIDTH-1:0] ram_wdata;
  logic [VECTOR_WIDTH-1:0] rd_a, rd_b;

  gnbpe_ram #(.WIDTH(VECTOR_WIDTH), .DEPTH(NODE_COUNT)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (ADDR_W'(in_i.source_a)),
    .rdata_o (rd_a)
  );

  gnbpe_ram #(.WIDTH(VECTOR_WIDTH), .DEPTH(NODE_COUNT)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (ADDR_W'(in_i.source_b)),
    .rdata_o (rd_b)
  );

  // ---------------------------------------------------------------------------
  // Write forward: the most recent store write. An item is read at the same
  // edge the previous item writes, so its read data may be stale for exactly
  // that slot; this register always holds the newest value for it.
  // ---------------------------------------------------------------------------
  logic                    lw_valid_q;
  logic [ADDR_W-1:0]       lw_slot_q;
  logic [VECTOR_WIDTH-1:0] lw_data_q;
  logic                    fwd_a, fwd_b;
  logic [VECTOR_WIDTH-1:0] opnd_a, opnd_b;

  assign fwd_a  = lw_valid_q && (lw_slot_q == ADDR_W'(s1_src_a_q));
  assign fwd_b  = lw_valid_q && (lw_slot_q == ADDR_W'(s1_src_b_q));
  assign opnd_a = fwd_a ? lw_data_q : rd_a;
  assign opnd_b = fwd_b ? lw_data_q : rd_b;

  // ---------------------------------------------------------------------------
  // Stage 1: slot check, gate evaluation, store write, slot counter update.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]        next_slot_q, next_slot_d;
  logic                    store_full;
  logic                    src_bad;
  logic                    s1_err;
  logic [VECTOR_WIDTH-1:0] s1_value;

  assign store_full = (next_slot_q == CNT_W'(NODE_COUNT));
  assign src_bad    = (CMP_W'(s1_src_a_q) >= CMP_W'(next_slot_q)) ||
                      (CMP_W'(s1_src_b_q) >= CMP_W'(next_slot_q));
  assign s1_err     = store_full || ((s1_action_q == ACT_GATE) && src_bad);
  assign s1_value   = (s1_action_q == ACT_GATE)
                    ? VECTOR_WIDTH'(gate_eval(s1_gate_q, VEC_PORT_W'(opnd_a),
                                              VEC_PORT_W'(opnd_b)))
                    : s1_vec_q;

  assign ram_we    = s1_adv && !s1_err;
  assign ram_waddr = ADDR_W'(next_slot_q);
  assign ram_wdata = s1_value;

  always_comb begin
    next_slot_d = next_slot_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        next_slot_d = '0;
      end else if (!s1_err) begin
        next_slot_d = next_slot_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot_q <= '0;
      lw_valid_q  <= 1'b0;
    end else begin
      next_slot_q <= next_slot_d;
      if (ram_we) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      lw_slot_q <= ram_waddr;
      lw_data_q <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. Rejected items report slot and value as zero.
  // ---------------------------------------------------------------------------
  logic                    out_valid_q, out_valid_d;
  logic [7:0]              out_slot_q;
  logic [VECTOR_WIDTH-1:0] out_value_q;
  logic                    out_err_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_slot_q  <= s1_err ? '0 : 8'(next_slot_q);
      out_value_q <= s1_err ? '0 : s1_value;
      out_err_q   <= s1_err;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.node_slot  = out_slot_q;
  assign out_o.node_value = VEC_PORT_W'(out_value_q);
  assign out_o.error      = out_err_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_slot_bound, clk_i, rst_ni, next_slot_q <= CNT_W'(NODE_COUNT))
  `ASSERT_NEXT(a_slot_step, clk_i, rst_ni, s1_adv && !s1_err && !s1_last_q, next_slot_q == $past(next_slot_q) + CNT_W'(1))
  `ASSERT_IMPLY(a_err_zero, clk_i, rst_ni, out_valid_q && out_err_q, out_slot_q == 8'd0 && out_value_q == '0)

endmodule

// ===== sim/gate_netlist_bit_parallel_evaluator_tb.sv =====
// Self-checking testbench for the bit-parallel gate netlist evaluator.
// Needs gnbpe_pkg, gnbpe_in_if, gnbpe_out_if and the evaluator RTL compiled first.
// Directed netlists, then random ones; every result is checked against a local predictor.
module gate_netlist_bit_parallel_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gnbpe_pkg::*;

  localparam int unsigned SLOTS        = NODE_COUNT_DEF;
  localparam int unsigned VW           = VECTOR_WIDTH_DEF;
  localparam logic [63:0] VMASK        = {64{1'b1}} >> (64 - VW);
  localparam int unsigned WAIT_MAX     = 13;
  localparam int unsigned IDLE_LIMIT   = 2000;  // far above the worst gap + stall + latency
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned TOTAL_ITEMS  = 1900;

  // One node as it travels over the input channel. drain_first holds the item
  // back until every result already owed has come out.
  typedef struct {
    action_e     action;
    gate_e       gate;
    logic [7:0]  src_a;
    logic [7:0]  src_b;
    logic [63:0] vec;
    logic        last;
    bit          drain_first;
  } node_item_t;

  typedef struct {
    logic [7:0]  slot;
    logic [63:0] value;
    logic        error;
  } node_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gnbpe_in_if  in_if ();
  gnbpe_out_if out_if ();

  gate_netlist_bit_parallel_evaluator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the signal store and the slot counter.
  // ---------------------------------------------------------------------------
  logic [63:0]  node_store [SLOTS];
  int unsigned  store_fill;          // next slot to be written, 0..SLOTS

  node_item_t   pending_nodes [$];   // stimulus not yet offered
  node_result_t node_results  [$];   // expected results, oldest first

  int unsigned  gen_fill;            // generator's view of store_fill
  int unsigned  n_queued, n_accepted, n_checked, n_rejects, n_full_rejects, n_netlists;
  int unsigned  n_fail;
  int unsigned  idle_cycles;

  function automatic logic [63:0] combine(gate_e g, logic [63:0] a, logic [63:0] b);
    case (g)
      GATE_AND:     return a & b;
      GATE_ANDNOTA: return ~a & b;
      GATE_ANDNOT:  return a & ~b;
      GATE_NOR:     return ~(a | b);
      GATE_NAND:    return ~(a & b);
      GATE_ORNOT:   return a | ~b;
      GATE_ORNOTA:  return ~a | b;
      default:      return a | b;
    endcase
  endfunction

  // Applies one accepted node to the predictor and returns the result it owes.
  function automatic node_result_t evaluate_node(node_item_t it);
    node_result_t r;
    logic [63:0]  v;
    bit           ok;
    r  = '{8'd0, 64'd0, 1'b1};
    v  = '0;
    ok = 1'b0;
    if (store_fill >= SLOTS) begin
      n_full_rejects++;
    end else if (it.action == ACT_GATE) begin
      // both operands must already sit below the write pointer
      if (it.src_a < store_fill && it.src_b < store_fill) begin
        v  = combine(it.gate, node_store[it.src_a], node_store[it.src_b]) & VMASK;
        ok = 1'b1;
      end
    end else begin
      v  = it.vec & VMASK;
      ok = 1'b1;
    end
    if (ok) begin
      node_store[store_fill] = v;
      r = '{8'(store_fill), v, 1'b0};
      store_fill++;
    end else begin
      n_rejects++;
    end
    // last mark rewinds even when the node itself was rejected
    if (it.last) store_fill = 0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Idle draw per transfer: half the time a wait up to WAIT_MAX, with occasional calm
  // stretches where no idling happens at all.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(16, 64);
    return ($urandom_range(0, 1) == 1) ? $urandom_range(0, WAIT_MAX) : 0;
  endfunction

  function automatic logic [63:0] rand_vector();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Operand slot for a well-formed gate; leans on the newest slot so the
  // write-forward path gets hit often.
  function automatic logic [7:0] pick_source();
    int unsigned sel;
    sel = $urandom_range(0, 5);
    if (gen_fill == 0 || gen_fill >= SLOTS) return 8'($urandom_range(0, 255));
    if (sel < 2) return 8'(gen_fill - 1);
    if (sel == 2) return 8'd0;
    return 8'($urandom_range(0, gen_fill - 1));
  endfunction

  // Queues one node and tracks where the slot counter will stand afterwards.
  task automatic queue_node(action_e act, gate_e g, logic [7:0] a, logic [7:0] b,
                            logic [63:0] vec, logic last, bit drain);
    node_item_t it;
    bit         ok;
    it = '{act, g, a, b, vec, last, drain};
    pending_nodes.push_back(it);
    n_queued++;
    ok = (gen_fill < SLOTS) && (act == ACT_LOAD || (a < gen_fill && b < gen_fill));
    if (ok) gen_fill++;
    if (last) gen_fill = 0;
  endtask

  // One netlist: primary-input loads first, then gates over written slots,
  // with a share of noise (random action, arbitrary or boundary sources).
  task automatic gen_netlist(int unsigned nodes, int unsigned inputs,
                             int unsigned noise_pct, bit drain);
    action_e    act;
    logic [7:0] a, b;
    for (int unsigned i = 0; i < nodes; i++) begin
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      if (i < inputs || gen_fill == 0) begin
        act = ACT_LOAD;
      end else if ($urandom_range(0, 99) < noise_pct) begin
        act = action_e'($urandom_range(ACT_LOAD, ACT_GATE));
        if ($urandom_range(0, 2) == 0) a = 8'(gen_fill);  // first slot not yet written
      end else begin
        act = ACT_GATE;
        a   = pick_source();
        b   = pick_source();
      end
      queue_node(act, gate_e'($urandom_range(GATE_AND, GATE_OR)), a, b, rand_vector(),
                 i == nodes - 1, drain && i == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending nodes on the input channel, predicts on transfer.
  // ---------------------------------------------------------------------------
  node_item_t  on_bus;
  int unsigned feed_wait, calm_feed;

  always @(posedge clk_i or negedge rst_ni) begin : feeder
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.action       <= ACT_LOAD;
      in_if.gate_type    <= GATE_AND;
      in_if.source_a     <= '0;
      in_if.source_b     <= '0;
      in_if.input_vector <= '0;
      in_if.last_node    <= 1'b0;
      feed_wait = 0;
      calm_feed = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        node_results.push_back(evaluate_node(on_bus));
        n_accepted++;
        if (on_bus.last) n_netlists++;
        feed_wait = draw_wait(calm_feed);
      end
      // a stalled offer stays on the bus untouched
      if (!in_if.valid || in_if.ready) begin
        if (feed_wait > 0) begin
          feed_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_nodes.size() > 0 &&
                     !(pending_nodes[0].drain_first && node_results.size() != 0)) begin
          on_bus = pending_nodes.pop_front();
          in_if.valid        <= 1'b1;
          in_if.action       <= on_bus.action;
          in_if.gate_type    <= on_bus.gate;
          in_if.source_a     <= on_bus.src_a;
          in_if.source_b     <= on_bus.src_b;
          in_if.input_vector <= on_bus.vec;
          in_if.last_node    <= on_bus.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, field-by-field check of every transfer.
  // ---------------------------------------------------------------------------
  int unsigned sink_wait, calm_sink;

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    node_result_t got, want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_wait = 0;
      calm_sink = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.node_slot, out_if.node_value, out_if.error};
        if (node_results.size() == 0) begin
          $error("result with nothing expected: slot %0d value %h error %b",
                 got.slot, got.value, got.error);
          n_fail++;
        end else begin
          want = node_results.pop_front();
          n_checked++;
          if (got.slot !== want.slot) begin
            $error("node_slot: expected %0d, got %0d", want.slot, got.slot);
            n_fail++;
          end
          if (got.value !== want.value) begin
            $error("node_value: expected %h, got %h", want.value, got.value);
            n_fail++;
          end
          if (got.error !== want.error) begin
            $error("error: expected %b, got %b", want.error, got.error);
            n_fail++;
          end
        end
        sink_wait = draw_wait(calm_sink);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles without a transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: build all stimulus, reset, run, drain, report.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int unsigned nodes, inputs, noise;
    bit          first;
    gen_fill = 0;
    rst_ni   = 1'b0;

    // Directed: loads with extreme vectors and extreme ignored gate fields
    queue_node(ACT_LOAD, GATE_OR, 8'hff, 8'hff, 64'd0, 1'b0, 1'b0);
    queue_node(ACT_LOAD, GATE_AND, 8'h00, 8'h00, '1, 1'b0, 1'b0);
    queue_node(ACT_LOAD, GATE_NAND, 8'h80, 8'h7f, {32{2'b01}}, 1'b0, 1'b0);
    queue_node(ACT_LOAD, GATE_NOR, 8'h55, 8'haa, {32{2'b10}}, 1'b0, 1'b0);
    // every gate code over the two checkerboards (slots 2 and 3)
    for (int k = GATE_AND; k <= GATE_OR; k++)
      queue_node(ACT_GATE, gate_e'(k), 8'd2, 8'd3, rand_vector(), 1'b0, 1'b0);
    // operand is the slot written one transfer earlier
    queue_node(ACT_GATE, GATE_AND, 8'd11, 8'd11, '0, 1'b0, 1'b0);
    queue_node(ACT_GATE, GATE_OR, 8'd12, 8'd1, '1, 1'b0, 1'b0);
    // source not yet written: equal to the write pointer, then far above it
    queue_node(ACT_GATE, GATE_AND, 8'd14, 8'd0, '0, 1'b0, 1'b0);
    queue_node(ACT_GATE, GATE_OR, 8'hff, 8'hff, '1, 1'b0, 1'b0);
    // last mark on a good load rewinds the store
    queue_node(ACT_LOAD, GATE_AND, 8'd0, 8'd0, '1, 1'b1, 1'b0);
    // after the rewind slot 0 is unwritten again; also let the pipe drain first
    queue_node(ACT_GATE, GATE_AND, 8'd0, 8'd0, '0, 1'b0, 1'b1);
    // rejected node carrying the last mark
    queue_node(ACT_GATE, GATE_NAND, 8'd5, 8'd5, '0, 1'b1, 1'b0);
    queue_node(ACT_LOAD, GATE_OR, 8'd0, 8'd0, rand_vector(), 1'b1, 1'b0);

    // Random netlists; the first one overruns the store so the full case shows
    // up, later ones are mostly small with an occasional store-sized netlist.
    first = 1'b1;
    while (n_queued < TOTAL_ITEMS) begin
      if (first)
        nodes = SLOTS + 12;
      else if ($urandom_range(0, 11) == 0)
        nodes = $urandom_range(SLOTS - 16, SLOTS + 16);
      else
        nodes = $urandom_range(1, 40);
      inputs = $urandom_range(1, (nodes < 8) ? nodes : 8);
      if (first)
        noise = 0;
      else
        noise = ($urandom_range(0, 7) == 0) ? 50 : $urandom_range(0, 8);
      gen_netlist(nodes, inputs, noise, first || $urandom_range(0, 9) == 0);
      first = 1'b0;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_nodes.size() > 0 || in_if.valid || node_results.size() > 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d node transfers over %0d netlists, %0d results checked.",
             n_accepted, n_netlists, n_checked);
    $display("Rejected nodes: %0d, of which %0d hit a full store.",
             n_rejects, n_full_rejects);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
